### rtl/cms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_pkg
// Types, constants and line-handling functions for the conflict marker
// splitter.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam logic [7:0] NEST_MAX = 8'd255;

    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // line flag bits
    localparam int FL_OPEN    = 0;
    localparam int FL_CLOSE   = 1;
    localparam int FL_EQEARLY = 2;
    localparam int FL_BEGUN   = 3;

    // output phases of one command
    localparam logic [3:0] PH_CR     = 4'd0;
    localparam logic [3:0] PH_LF     = 4'd1;
    localparam logic [3:0] PH_BYTE0  = 4'd2;
    localparam logic [3:0] PH_STATUS = 4'd10;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_EOF  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        SEC_COMMON    = 3'd0,
        SEC_WORK      = 3'd1,
        SEC_NEW       = 3'd2,
        SEC_NEST_WORK = 3'd3,
        SEC_NEST_NEW  = 3'd4
    } section_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_working;
        logic       to_new;
        logic       is_status;
        logic       had_conflict;
        logic       nested_seen;
        logic       last;
    } result_t;

    // everything one input item asks the back end to write
    typedef struct packed {
        logic            nl;
        logic            nsw;
        logic            nsn;
        logic            crlf;
        logic            bw;
        logic            bn;
        logic [3:0]      cnt;
        logic [7:0][7:0] bytes;
        logic            status;
        logic            st_conf;
        logic            st_nest;
    } cmd_t;

    typedef struct packed {
        section_t        sec;
        logic [7:0]      dep;
        logic            ws;
        logic            ns;
        logic            cf;
        logic            nf;
        logic [7:0][7:0] win;
        logic [3:0]      pos;
        logic [3:0]      fl;
        logic            pcr;
        logic            mode;
        cmd_t            cmd;
    } work_t;

    function automatic logic goes_w(section_t s);
        return (s != SEC_NEW) && (s != SEC_NEST_NEW);
    endfunction

    function automatic logic goes_n(section_t s);
        return (s != SEC_WORK) && (s != SEC_NEST_WORK);
    endfunction

    function automatic logic [3:0] pend_count(work_t w);
        logic [3:0] r;
        if (w.sec == SEC_NEW && w.fl[FL_CLOSE]) begin
            r = 4'd0;
        end else if (w.pos > 4'd8) begin
            r = 4'd8;
        end else begin
            r = w.pos;
        end
        return r;
    endfunction

    function automatic logic is_open(logic [7:0][7:0] win);
        logic ok;
        ok = (win[7] == CH_SP);
        for (int i = 0; i < 7; i++) begin
            ok = ok && (win[i] == CH_LT);
        end
        return ok;
    endfunction

    function automatic logic is_close(logic [7:0][7:0] win);
        logic ok;
        ok = (win[7] == CH_SP);
        for (int i = 0; i < 7; i++) begin
            ok = ok && (win[i] == CH_GT);
        end
        return ok;
    endfunction

    // seven '=' starting at entry 0, or at entry 1 when hi is set
    function automatic logic sep_at(logic [7:0][7:0] win, logic hi);
        logic lo_ok;
        logic hi_ok;
        lo_ok = 1'b1;
        hi_ok = 1'b1;
        for (int i = 0; i < 7; i++) begin
            lo_ok = lo_ok && (win[i] == CH_EQ);
            hi_ok = hi_ok && (win[i + 1] == CH_EQ);
        end
        return hi ? hi_ok : lo_ok;
    endfunction

    function automatic work_t begin_line(work_t w);
        logic ww;
        logic wn;
        logic sw;
        logic sn;
        ww = goes_w(w.sec);
        wn = goes_n(w.sec);
        sw = ww && w.ws;
        sn = wn && w.ns;
        if (!w.fl[FL_BEGUN]) begin
            w.fl[FL_BEGUN] = 1'b1;
            if (sw || sn) begin
                w.cmd.nl  = 1'b1;
                w.cmd.nsw = sw;
                w.cmd.nsn = sn;
            end
            if (ww) w.ws = 1'b1;
            if (wn) w.ns = 1'b1;
        end
        return w;
    endfunction

    function automatic work_t emit(work_t w, logic [7:0] b);
        w = begin_line(w);
        w.cmd.bw = goes_w(w.sec);
        w.cmd.bn = goes_n(w.sec);
        w.cmd.bytes[w.cmd.cnt[2:0]] = b;
        w.cmd.cnt = w.cmd.cnt + 4'd1;
        return w;
    endfunction

    function automatic work_t flush(work_t w, logic [3:0] k);
        w = begin_line(w);
        w.cmd.bw = goes_w(w.sec);
        w.cmd.bn = goes_n(w.sec);
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < k) begin
                w.cmd.bytes[w.cmd.cnt[2:0]] = w.win[i];
                w.cmd.cnt = w.cmd.cnt + 4'd1;
            end
        end
        return w;
    endfunction

    function automatic work_t push_byte(work_t w, logic [7:0] c);
        logic [3:0] pend;
        pend = pend_count(w);
        if (!(w.sec == SEC_NEW && w.fl[FL_CLOSE])) begin
            if (w.sec == SEC_WORK && pend >= 4'd7 && sep_at(w.win, pend == 4'd8)) begin
                w.fl[FL_EQEARLY] = 1'b1;
            end
            if (pend == 4'd8) begin
                if (!(w.sec == SEC_COMMON && w.fl[FL_OPEN])) begin
                    w = emit(w, w.win[0]);
                end
                for (int i = 0; i < 7; i++) begin
                    w.win[i] = w.win[i + 1];
                end
                pend = 4'd7;
            end
            w.win[pend[2:0]] = c;
            if (w.pos < 4'd9) w.pos = w.pos + 4'd1;
            if (w.pos == 4'd8 && is_open(w.win)) w.fl[FL_OPEN] = 1'b1;
            if (pend == 4'd7 && !w.fl[FL_OPEN] &&
                (w.sec == SEC_NEW || w.sec == SEC_NEST_WORK || w.sec == SEC_NEST_NEW) &&
                is_close(w.win)) begin
                w.fl[FL_CLOSE] = 1'b1;
            end
        end
        return w;
    endfunction

    function automatic work_t nested_line(work_t w, section_t back);
        w = flush(w, pend_count(w));
        if (w.fl[FL_OPEN]) begin
            if (w.dep < NEST_MAX) w.dep = w.dep + 8'd1;
        end else if (w.fl[FL_CLOSE]) begin
            if (w.dep == 8'd0) begin
                w.sec = back;
            end else begin
                w.dep = w.dep - 8'd1;
            end
        end
        return w;
    endfunction

    function automatic work_t end_line(work_t w);
        logic       open;
        logic [3:0] pend;
        open = w.fl[FL_OPEN];
        pend = pend_count(w);
        case (w.sec)
            SEC_WORK: begin
                if (open) begin
                    w = flush(w, pend);
                    w.sec = SEC_NEST_WORK;
                end else if (pend >= 4'd7 && !w.fl[FL_EQEARLY] &&
                             sep_at(w.win, pend == 4'd8)) begin
                    if (pend > 4'd7 || w.fl[FL_BEGUN]) w = flush(w, pend - 4'd7);
                    w.sec = SEC_NEW;
                end else begin
                    w = flush(w, pend);
                end
            end
            SEC_NEW: begin
                if (open) begin
                    w = flush(w, pend);
                    w.sec = SEC_NEST_NEW;
                end else if (w.fl[FL_CLOSE]) begin
                    w.sec = SEC_COMMON;
                end else begin
                    w = flush(w, pend);
                end
            end
            SEC_NEST_WORK: begin
                w.nf = 1'b1;
                w = nested_line(w, SEC_WORK);
            end
            SEC_NEST_NEW: begin
                w = nested_line(w, SEC_NEW);
            end
            default: begin
                if (open) begin
                    w.sec = SEC_WORK;
                    w.cf = 1'b1;
                end else begin
                    w = flush(w, pend);
                end
            end
        endcase
        w.pos = 4'd0;
        w.fl  = 4'd0;
        w.pcr = 1'b0;
        return w;
    endfunction

endpackage
`default_nettype wire

### rtl/cms_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_front
// Takes one file byte or end of file per transfer, runs the section machine
// and line window, and hands a write command to the queue.
// ----------------------------------------------------------------------------
module cms_front
    import cms_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_item,
    input  wire logic  mode,
    input  wire logic  q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    section_t        sec_reg;
    logic [7:0]      dep_reg;
    logic            ws_reg, ns_reg, cf_reg, nf_reg, pcr_reg;
    logic [7:0][7:0] win_reg;
    logic [3:0]      pos_reg, fl_reg;
    work_t           w_next;
    logic            accept;
    logic            has_res;

    always_comb begin
        w_next     = '0;
        w_next.sec = sec_reg;
        w_next.dep = dep_reg;
        w_next.ws  = ws_reg;
        w_next.ns  = ns_reg;
        w_next.cf  = cf_reg;
        w_next.nf  = nf_reg;
        w_next.win = win_reg;
        w_next.pos = pos_reg;
        w_next.fl  = fl_reg;
        w_next.pcr = pcr_reg;
        w_next.mode = mode;
        w_next.cmd.crlf = !mode;
        if (s_item.operation == OP_EOF) begin
            if (w_next.pos != 4'd0 || w_next.pcr) w_next = end_line(w_next);
            w_next.cmd.status  = 1'b1;
            w_next.cmd.st_conf = w_next.cf;
            w_next.cmd.st_nest = w_next.nf;
            w_next.sec = SEC_COMMON;
            w_next.dep = 8'd0;
            w_next.ws  = 1'b0;
            w_next.ns  = 1'b0;
            w_next.cf  = 1'b0;
            w_next.nf  = 1'b0;
            w_next.pos = 4'd0;
            w_next.fl  = 4'd0;
            w_next.pcr = 1'b0;
        end else if (w_next.pcr && s_item.data_byte == CH_LF) begin
            // CR LF pair closes the line
            w_next.pcr = 1'b0;
            w_next = end_line(w_next);
        end else begin
            if (w_next.pcr) begin
                // lone CR is line text
                w_next.pcr = 1'b0;
                w_next = push_byte(w_next, CH_CR);
            end
            if (s_item.data_byte == CH_LF) begin
                w_next = end_line(w_next);
            end else if (s_item.data_byte == CH_CR && !mode) begin
                w_next.pcr = 1'b1;
            end else begin
                w_next = push_byte(w_next, s_item.data_byte);
            end
        end
    end

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign has_res  = w_next.cmd.nl || (w_next.cmd.cnt != 4'd0) || w_next.cmd.status;
    assign push     = accept && has_res;
    assign push_cmd = w_next.cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg <= SEC_COMMON;
            dep_reg <= 8'd0;
            ws_reg  <= 1'b0;
            ns_reg  <= 1'b0;
            cf_reg  <= 1'b0;
            nf_reg  <= 1'b0;
            pos_reg <= 4'd0;
            fl_reg  <= 4'd0;
            pcr_reg <= 1'b0;
        end else if (accept) begin
            sec_reg <= w_next.sec;
            dep_reg <= w_next.dep;
            ws_reg  <= w_next.ws;
            ns_reg  <= w_next.ns;
            cf_reg  <= w_next.cf;
            nf_reg  <= w_next.nf;
            pos_reg <= w_next.pos;
            fl_reg  <= w_next.fl;
            pcr_reg <= w_next.pcr;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) win_reg <= w_next.win;
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 4'd9)
        else $error("line position beyond saturation");

    a_depth_nested_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (sec_reg != SEC_NEST_WORK && sec_reg != SEC_NEST_NEW) |-> dep_reg == 8'd0)
        else $error("nesting depth nonzero outside nested section");

endmodule
`default_nettype wire

### rtl/cms_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module cms_queue
    import cms_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t       ent_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = ent_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (do_push) wr_reg <= !wr_reg;
            if (do_pop) rd_reg <= !rd_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) ent_reg[wr_reg] <= push_cmd;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("queue count overflow");

endmodule
`default_nettype wire

### rtl/cms_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_back
// Walks head command one result per ready cycle: newline, line bytes, status.
// ----------------------------------------------------------------------------
module cms_back
    import cms_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic head_valid,
    input  wire cmd_t head_cmd,
    output logic      pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output result_t   m_result
);

    logic [3:0]  ph_reg, ph_next;
    logic        mv_reg;
    result_t     res_reg, res_next;
    logic [10:0] pm, above, rest;
    logic [3:0]  cur, nxt;
    logic        any_rest;
    logic        load;
    logic [3:0]  bidx;

    always_comb begin
        pm = '0;
        pm[PH_CR] = head_cmd.nl && head_cmd.crlf;
        pm[PH_LF] = head_cmd.nl;
        for (int i = 0; i < 8; i++) begin
            pm[i + 2] = (4'(i) < head_cmd.cnt);
        end
        pm[PH_STATUS] = head_cmd.status;
        above = pm & ~((11'd1 << ph_reg) - 11'd1);
        cur = PH_STATUS;
        for (int i = 10; i >= 0; i--) begin
            if (above[i]) cur = 4'(i);
        end
        rest = above & ~(11'd1 << cur);
        any_rest = (rest != 11'd0);
        nxt = PH_STATUS;
        for (int i = 10; i >= 0; i--) begin
            if (rest[i]) nxt = 4'(i);
        end
    end

    assign load = head_valid && (!mv_reg || m_ready);
    assign pop  = load && !any_rest;
    assign bidx = cur - PH_BYTE0;

    always_comb begin
        res_next = '0;
        res_next.last = !any_rest;
        if (cur == PH_CR) begin
            res_next.out_byte   = CH_CR;
            res_next.to_working = head_cmd.nsw;
            res_next.to_new     = head_cmd.nsn;
        end else if (cur == PH_LF) begin
            res_next.out_byte   = CH_LF;
            res_next.to_working = head_cmd.nsw;
            res_next.to_new     = head_cmd.nsn;
        end else if (cur == PH_STATUS) begin
            res_next.is_status    = 1'b1;
            res_next.had_conflict = head_cmd.st_conf;
            res_next.nested_seen  = head_cmd.st_nest;
        end else begin
            res_next.out_byte   = head_cmd.bytes[bidx[2:0]];
            res_next.to_working = head_cmd.bw;
            res_next.to_new     = head_cmd.bn;
        end
        ph_next = ph_reg;
        if (load) ph_next = any_rest ? nxt : PH_CR;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_CR;
            mv_reg <= 1'b0;
        end else begin
            ph_reg <= ph_next;
            if (load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) res_reg <= res_next;
    end

    assign m_valid  = mv_reg;
    assign m_result = res_reg;

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ph_reg <= PH_STATUS)
        else $error("output phase out of range");

endmodule
`default_nettype wire

### rtl/conflict_marker_splitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conflict_marker_splitter
// Splits a merge-conflict file into working-copy and new-revision streams.
// ----------------------------------------------------------------------------
// Feed one file byte per transfer (operation 0), then one end-of-file
// transfer (operation 1), which yields a status result. The front end takes
// one input transfer per cycle as long as its two-entry command queue has
// room; the back end sends one result per cycle while m_ready is high, and
// an input can cause up to 11 results (a newline pair, up to eight held line
// bytes, status). Most bytes cause zero or one result; bursts come at line
// ends when the 8-byte window is flushed. newline_mode must be written
// through cfg_valid/cfg_data only while the block is idle; the block itself
// does not enforce this (0: CR LF, 1: LF only).
// ----------------------------------------------------------------------------
module conflict_marker_splitter
    import cms_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_item,
    output logic       m_valid,
    input  wire logic  m_ready,
    output result_t    m_result,
    input  wire logic  cfg_valid,
    output logic       cfg_ready,
    input  wire logic  cfg_data
);

    logic mode_reg;
    logic q_full, push, pop, head_valid;
    cmd_t push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    cms_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .mode     (mode_reg),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    cms_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    cms_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

endmodule
`default_nettype wire
